/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [7:0] CODE_SPACE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'd7;
    localparam int         TAB_BITS     = 3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_SCROLL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        FILL_ONE,
        FILL_LINE,
        FILL_TAB
    } fill_t;

endpackage

`default_nettype wire

/* hdl/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with a scrolling screen store.
// ----------------------------------------------------------------------------
// After reset the block clears its ROWS*COLS screen store one cell a cycle
// with busy high. An item is taken when start is high and busy is low; its
// result appears on done for one cycle and cannot be held off. A read passes
// ST_READ, a carriage return goes straight to ST_DONE, a printable character
// writes one cell, a tab fills to the next column that is a multiple of 8,
// and a newline fills to the end of the row. Every fill writes one cell a
// cycle through the single RAM write port; passing the last cell adds a pass
// clearing the row that scrolls in, since scrolling only moves a row offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       kind,
    input  wire logic [7:0] char_code,
    input  wire logic [4:0] read_row,
    input  wire logic [6:0] read_col,
    input  wire logic       text_attribute_we,
    input  wire logic [7:0] text_attribute,
    output logic            done,
    output logic      [7:0] cell_char,
    output logic      [7:0] cell_attr,
    output logic      [4:0] cursor_row,
    output logic      [6:0] cursor_col
);

    import tcw_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int AW = $clog2(ROWS * COLS);

    state_t         state_reg, state_next;
    fill_t          mode_reg, mode_next;
    logic [7:0]     attr_reg;
    logic [7:0]     fill_char_reg, fill_char_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic [RW-1:0]  top_reg, top_next;
    logic [RW-1:0]  clr_row_reg, clr_row_next;
    logic [CW-1:0]  clr_col_reg, clr_col_next;
    logic           in_range_reg, in_range_next;
    logic [7:0]     cell_char_reg, cell_char_next;
    logic [7:0]     cell_attr_reg, cell_attr_next;

    logic [RW-1:0]  addr_row;
    logic [CW-1:0]  addr_col;
    logic [AW-1:0]  addr;
    logic           ram_we;
    logic [15:0]    ram_wdata;
    logic [15:0]    ram_rdata;
    logic [31:0]    rrow_ext;
    logic [31:0]    rcol_ext;
    logic [31:0]    crow_ext;
    logic [31:0]    ccol_ext;
    logic [CW-1:0]  col_inc;
    logic           col_wrap;
    logic           read_ok;

    tcw_addr_unit #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_addr (
        .row  (addr_row),
        .col  (addr_col),
        .top  (top_reg),
        .addr (addr)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (ROWS * COLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            mode_reg     <= FILL_ONE;
            attr_reg     <= ATTR_RESET;
            cur_row_reg  <= RW'(ROWS - 1);
            cur_col_reg  <= '0;
            top_reg      <= '0;
            clr_row_reg  <= '0;
            clr_col_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            top_reg      <= top_next;
            clr_row_reg  <= clr_row_next;
            clr_col_reg  <= clr_col_next;
            if (text_attribute_we)
            begin
                attr_reg <= text_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_char_reg <= fill_char_next;
        in_range_reg  <= in_range_next;
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
    end

    always_comb
    begin
        rrow_ext = 32'(read_row);
        rcol_ext = 32'(read_col);
        read_ok  = (rrow_ext < ROWS) && (rcol_ext < COLS);
        col_wrap = (cur_col_reg == CW'(COLS - 1));
        col_inc  = cur_col_reg + CW'(1);

        state_next     = state_reg;
        mode_next      = mode_reg;
        fill_char_next = fill_char_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        clr_row_next   = clr_row_reg;
        clr_col_next   = clr_col_reg;
        in_range_next  = in_range_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        addr_row       = cur_row_reg;
        addr_col       = cur_col_reg;
        ram_we         = 1'b0;
        ram_wdata      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                addr_row = clr_row_reg;
                addr_col = clr_col_reg;
                ram_we   = 1'b1;
                if (clr_col_reg == CW'(COLS - 1))
                begin
                    clr_col_next = '0;
                    if (clr_row_reg == RW'(ROWS - 1))
                    begin
                        clr_row_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        clr_row_next = clr_row_reg + RW'(1);
                    end
                end
                else
                begin
                    clr_col_next = clr_col_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                addr_row = rrow_ext[RW-1:0];
                addr_col = rcol_ext[CW-1:0];
                if (start)
                begin
                    cell_char_next = '0;
                    cell_attr_next = '0;
                    if (kind)
                    begin
                        in_range_next = read_ok;
                        state_next    = ST_READ;
                    end
                    else if (char_code == CODE_RETURN)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (char_code == CODE_NEWLINE)
                    begin
                        mode_next      = FILL_LINE;
                        fill_char_next = CODE_SPACE;
                        state_next     = ST_FILL;
                    end
                    else if (char_code == CODE_TAB)
                    begin
                        mode_next      = FILL_TAB;
                        fill_char_next = CODE_SPACE;
                        state_next     = ST_FILL;
                    end
                    else
                    begin
                        mode_next      = FILL_ONE;
                        fill_char_next = char_code;
                        state_next     = ST_FILL;
                    end
                end
            end
            ST_READ:
            begin
                if (in_range_reg)
                begin
                    cell_char_next = ram_rdata[7:0];
                    cell_attr_next = ram_rdata[15:8];
                end
                state_next = ST_DONE;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = {attr_reg, fill_char_reg};
                if (col_wrap)
                begin
                    cur_col_next = '0;
                    if (cur_row_reg == RW'(ROWS - 1))
                    begin
                        clr_col_next = '0;
                        state_next   = ST_SCROLL;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + RW'(1);
                        state_next   = ST_DONE;
                    end
                end
                else
                begin
                    cur_col_next = col_inc;
                    if (mode_reg == FILL_ONE ||
                        (mode_reg == FILL_TAB && col_inc[TAB_BITS-1:0] == '0))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCROLL:
            begin
                // logical row 0 is the old top row, which becomes the new bottom
                addr_row = '0;
                addr_col = clr_col_reg;
                ram_we   = 1'b1;
                if (clr_col_reg == CW'(COLS - 1))
                begin
                    clr_col_next = '0;
                    if (top_reg == RW'(ROWS - 1))
                    begin
                        top_next = '0;
                    end
                    else
                    begin
                        top_next = top_reg + RW'(1);
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    clr_col_next = clr_col_reg + CW'(1);
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        crow_ext   = 32'(cur_row_reg);
        ccol_ext   = 32'(cur_col_reg);
        cursor_row = crow_ext[4:0];
        cursor_col = ccol_ext[6:0];
        busy       = (state_reg != ST_IDLE);
        done       = (state_reg == ST_DONE);
        cell_char  = cell_char_reg;
        cell_attr  = cell_attr_reg;
    end

endmodule

`default_nettype wire

/* hdl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/tcw_addr_unit.sv */
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared address unit: maps a logical row through the scroll offset to a
// physical row and forms the linear cell address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_addr_unit #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic [$clog2(ROWS)-1:0]      row,
    input  wire logic [$clog2(COLS)-1:0]      col,
    input  wire logic [$clog2(ROWS)-1:0]      top,
    output logic      [$clog2(ROWS*COLS)-1:0] addr
);

    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(ROWS * COLS);

    logic [RW:0] sum;
    logic [RW:0] prow;

    always_comb
    begin
        sum = {1'b0, row} + {1'b0, top};
        if (32'(sum) >= ROWS)
        begin
            prow = sum - (RW+1)'(ROWS);
        end
        else
        begin
            prow = sum;
        end
        addr = AW'(32'(prow) * COLS) + AW'(col);
    end

endmodule

`default_nettype wire
